// ----- sv/apt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apt_pkg: shared definitions of the audio period position tracker
// Stream geometry, field widths, register indexes and reset values.
// ----------------------------------------------------------------------------
package apt_pkg;

  localparam int MAX_CARDS       = 4;
  localparam int PCMS_PER_CARD   = 2;
  localparam int PLAYBACK_SUBS   = 4;
  localparam int STREAMS_PER_PCM = PLAYBACK_SUBS + 1;
  localparam int STREAM_TOTAL    = MAX_CARDS * PCMS_PER_CARD * STREAMS_PER_PCM;
  localparam int SLOT_W          = $clog2(STREAM_TOTAL);

  localparam int CARD_W = 3;
  localparam int PCM_W  = 2;
  localparam int SUB_W  = 3;
  localparam int POS_W  = 64;
  localparam int PF_W   = 24;
  localparam int PC_W   = 11;
  localparam int CARDS_W = 3;
  localparam int IDX_W  = 10;
  localparam int FRAG_W = 32;
  localparam int CNT_W  = $clog2(POS_W);

  localparam logic [PC_W-1:0] INDEX_LIMIT = 11'd1024;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 48;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_FRAMES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CARDS_PRESENT = 2'd2;

  localparam logic [PF_W-1:0]    PF_RESET    = 24'd1024;
  localparam logic [PC_W-1:0]    PC_RESET    = 11'd2;
  localparam logic [CARDS_W-1:0] CARDS_RESET = 3'd1;

  typedef struct packed {
    logic [POS_W-1:0]  bnd;
    logic [IDX_W-1:0]  period;
    logic [FRAG_W-1:0] frag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- sv/apt_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apt_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module apt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/audio_period_position_tracker_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_period_position_tracker_core: per-stream period boundary tracker
// Advances stored period boundaries from timer-notify position reports.
// ----------------------------------------------------------------------------
// The in_ channel carries one report per transfer: stream address, running
// flag and 64-bit sample position. The out_ channel returns one result per
// report: error flag, elapsed flag, ring period index and fragment. The cfg_
// port writes period_frames, period_count and cards_present at any edge at
// which cfg_wr_en is high; writes belong between reports.
// A report is taken only while the sequencer is idle. For an out-of-range
// address the sequencer goes straight to its done state and reads no RAM.
// A valid report reads its stream entry from RAM in the read state and is
// checked in the evaluate state; when one or more periods elapse, divide
// and index states follow. The period step count is found by a bit-serial
// divide of the distance by the period size, one quotient bit per cycle over
// all 64 bits, which also tracks the step count modulo the period count. A
// report is not taken until the previous one has left the done state. The
// result waits in an output register; a new report is taken while it waits,
// and that report's result is held back until the receiver takes the earlier
// one. Reset restores the registers to their defaults and marks all stream
// entries as cleared at once.
// ----------------------------------------------------------------------------
module audio_period_position_tracker_core
  import apt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // card, pcm device, substream, capture select, running flag,
  // sample position
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // index_error, period_elapsed, period_index, period_fragment
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_IDX  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [PF_W-1:0]    pf_r, pf_nxt;
  logic [PC_W-1:0]    pc_r, pc_nxt;
  logic [CARDS_W-1:0] cards_r, cards_nxt;
  logic [STREAM_TOTAL-1:0] valid_r, valid_nxt;

  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic               run_r, run_nxt;
  logic               err_r, err_nxt;
  logic [POS_W-1:0]   bnd_r, bnd_nxt;
  logic [IDX_W-1:0]   per_r, per_nxt;
  logic               elapsed_r, elapsed_nxt;
  logic [IDX_W-1:0]   res_idx_r, res_idx_nxt;
  logic [FRAG_W-1:0]  res_frag_r, res_frag_nxt;
  logic               wr_pend_r, wr_pend_nxt;

  logic [POS_W-1:0]   div_shift_r, div_shift_nxt;
  logic [PF_W-1:0]    rem_r, rem_nxt;
  logic [IDX_W-1:0]   qmod_r, qmod_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [CARD_W-1:0] in_card;
  logic [PCM_W-1:0]  in_pcm;
  logic [SUB_W-1:0]  in_sub;
  logic              in_cap;
  logic              in_run;
  logic [POS_W-1:0]  in_pos;
  logic              in_err;
  logic [SLOT_W-1:0] in_slot;

  logic [PC_W-1:0]   pc_eff;
  logic              ram_wr_en;
  logic              ram_rd_en;
  entry_t            ram_wr_data;
  logic [ENTRY_W-1:0] ram_rd_data;
  entry_t            entry;
  logic [POS_W-1:0]  diff;
  logic              advance;
  logic [PF_W:0]     trial;
  logic              ge;
  logic [PC_W-1:0]   qm;
  logic [PC_W-1:0]   p_inc;
  logic [PC_W-1:0]   p_one;
  logic [PC_W-1:0]   steps_m1;
  logic [PC_W:0]     p_sum;
  logic [IDX_W-1:0]  p_new;
  logic              take;
  logic              deliver;

  assign in_card = in_tdata[2:0];
  assign in_pcm  = in_tdata[4:3];
  assign in_sub  = in_tdata[7:5];
  assign in_cap  = in_tdata[8];
  assign in_run  = in_tdata[9];
  assign in_pos  = in_tdata[73:10];

  assign in_err = (in_card >= cards_r) ||
                  ({1'b0, in_card} >= 4'(MAX_CARDS)) ||
                  ({1'b0, in_pcm} >= 3'(PCMS_PER_CARD)) ||
                  ({1'b0, in_sub} >= 4'(PLAYBACK_SUBS));
  assign in_slot = SLOT_W'((int'(in_card) * PCMS_PER_CARD + int'(in_pcm)) * STREAMS_PER_PCM +
                           (in_cap ? PLAYBACK_SUBS : int'(in_sub)));

  assign pc_eff = (pc_r > INDEX_LIMIT) ? INDEX_LIMIT : pc_r;

  assign in_tready  = (state_r == S_IDLE);
  assign take       = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign deliver    = (state_r == S_DONE) && (!out_valid_r || out_tready);

  assign ram_rd_en   = (state_r == S_READ);
  assign ram_wr_en   = deliver && wr_pend_r;
  assign ram_wr_data = '{bnd: bnd_r, period: res_idx_r, frag: res_frag_r};

  apt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STREAM_TOTAL)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (slot_r),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (slot_r),
    .rd_data (ram_rd_data)
  );

  assign entry   = valid_r[slot_r] ? entry_t'(ram_rd_data) : '0;
  assign diff    = pos_r - entry.bnd;
  assign advance = run_r && (pf_r != '0) && (pos_r >= entry.bnd) &&
                   (diff >= {{(POS_W-PF_W){1'b0}}, pf_r});

  assign trial = {rem_r, div_shift_r[POS_W-1]};
  assign ge    = (trial >= {1'b0, pf_r});
  assign qm    = {qmod_r, ge};

  assign p_inc    = {1'b0, per_r} + 1'b1;
  assign p_one    = (p_inc >= pc_eff) ? '0 : p_inc;
  assign steps_m1 = (qmod_r == '0) ? (pc_eff - 1'b1) : ({1'b0, qmod_r} - 1'b1);
  assign p_sum    = {1'b0, p_one} + {1'b0, steps_m1};
  always_comb begin
    if (pc_eff == '0) begin
      p_new = '0;
    end else if (p_sum >= {1'b0, pc_eff}) begin
      p_new = IDX_W'(p_sum - {1'b0, pc_eff});
    end else begin
      p_new = p_sum[IDX_W-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pf_nxt        = pf_r;
    pc_nxt        = pc_r;
    cards_nxt     = cards_r;
    valid_nxt     = valid_r;
    pos_nxt       = pos_r;
    slot_nxt      = slot_r;
    run_nxt       = run_r;
    err_nxt       = err_r;
    bnd_nxt       = bnd_r;
    per_nxt       = per_r;
    elapsed_nxt   = elapsed_r;
    res_idx_nxt   = res_idx_r;
    res_frag_nxt  = res_frag_r;
    wr_pend_nxt   = wr_pend_r;
    div_shift_nxt = div_shift_r;
    rem_nxt       = rem_r;
    qmod_nxt      = qmod_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PERIOD_FRAMES: pf_nxt    = cfg_wdata[PF_W-1:0];
        CFG_PERIOD_COUNT:  pc_nxt    = cfg_wdata[PC_W-1:0];
        CFG_CARDS_PRESENT: cards_nxt = cfg_wdata[CARDS_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (take) begin
          pos_nxt      = in_pos;
          slot_nxt     = in_slot;
          run_nxt      = in_run;
          err_nxt      = in_err;
          elapsed_nxt  = 1'b0;
          res_idx_nxt  = '0;
          res_frag_nxt = '0;
          wr_pend_nxt  = 1'b0;
          state_nxt    = in_err ? S_DONE : S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        bnd_nxt      = entry.bnd;
        per_nxt      = entry.period;
        res_idx_nxt  = entry.period;
        res_frag_nxt = run_r ? diff[FRAG_W-1:0] : entry.frag;
        wr_pend_nxt  = run_r;
        if (advance) begin
          div_shift_nxt = diff;
          rem_nxt       = '0;
          qmod_nxt      = '0;
          cnt_nxt       = '0;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        rem_nxt       = ge ? PF_W'(trial - {1'b0, pf_r}) : trial[PF_W-1:0];
        div_shift_nxt = {div_shift_r[POS_W-2:0], 1'b0};
        if (pc_eff == '0) begin
          qmod_nxt = '0;
        end else if (qm >= pc_eff) begin
          qmod_nxt = IDX_W'(qm - pc_eff);
        end else begin
          qmod_nxt = qm[IDX_W-1:0];
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(POS_W - 1)) begin
          state_nxt = S_IDX;
        end
      end
      S_IDX: begin
        bnd_nxt      = pos_r - {{(POS_W-PF_W){1'b0}}, rem_r};
        res_idx_nxt  = p_new;
        res_frag_nxt = FRAG_W'(rem_r);
        elapsed_nxt  = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (deliver) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{(OUT_DATA_W-FRAG_W-IDX_W-2){1'b0}},
                           res_frag_r, res_idx_r, elapsed_r, err_r};
          if (wr_pend_r) begin
            valid_nxt[slot_r] = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pf_r        <= PF_RESET;
      pc_r        <= PC_RESET;
      cards_r     <= CARDS_RESET;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pf_r        <= pf_nxt;
      pc_r        <= pc_nxt;
      cards_r     <= cards_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    slot_r      <= slot_nxt;
    run_r       <= run_nxt;
    err_r       <= err_nxt;
    bnd_r       <= bnd_nxt;
    per_r       <= per_nxt;
    elapsed_r   <= elapsed_nxt;
    res_idx_r   <= res_idx_nxt;
    res_frag_r  <= res_frag_nxt;
    wr_pend_r   <= wr_pend_nxt;
    div_shift_r <= div_shift_nxt;
    rem_r       <= rem_nxt;
    qmod_r      <= qmod_nxt;
    cnt_r       <= cnt_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

// ----- sv/apt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apt_checker: port-level checks of the period position tracker
// Watches the top-level ports and flags handshake and result violations.
// ----------------------------------------------------------------------------
module apt_checker
  import apt_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn before its transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("stalled result changed");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("report taken while the previous one is in progress");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> (out_tdata[OUT_DATA_W-1:1] == '0))
    else $error("error result carries nonzero fields");

endmodule

bind audio_period_position_tracker_core apt_checker u_apt_checker (.*);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of audio_period_position_tracker_core
// Sends position reports through the in_ stream and checks every result on
// the out_ stream against a per-stream period tracking model or typed table
// values. A short table of directed reports and register writes comes first.
// Random reports then follow under changing registers and three idle patterns.
// ----------------------------------------------------------------------------
module tb;
  import apt_pkg::*;

  localparam int CLK_HALF      = 1;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 80;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SEGMENTS      = 4;
  localparam int SEG_ITEMS     = 71;
  localparam int PLAN_LEN      = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic              running;
    logic              capture;
    logic [SUB_W-1:0]  sub;
    logic [PCM_W-1:0]  pcm;
    logic [CARD_W-1:0] card;
  } report_t;

  typedef struct packed {
    logic [FRAG_W-1:0] fragment;
    logic [IDX_W-1:0]  index;
    logic              elapsed;
    logic              error;
  } result_t;

  typedef enum {ROW_REPORT, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [CARD_W-1:0]     card;
    logic [PCM_W-1:0]      pcm;
    logic [SUB_W-1:0]      sub;
    logic                  capture;
    logic                  running;
    logic [POS_W-1:0]      pos;
    bit                    typed;
    logic                  err;
    logic                  el;
    logic [IDX_W-1:0]      idx;
    logic [FRAG_W-1:0]     frag;
  } plan_row_t;

  // Columns: kind, register, value, card, pcm, sub, capture, running,
  // position, typed, error, elapsed, index, fragment.
  plan_row_t plan [PLAN_LEN] = '{
    '{ROW_REPORT, 0, 0, 0, 0, 0, 0, 1, 64'd0, 1, 0, 0, 0, 0},
    '{ROW_REPORT, 0, 0, 0, 0, 0, 0, 1, 64'd1023, 1, 0, 0, 0, 1023},
    '{ROW_REPORT, 0, 0, 0, 0, 0, 0, 1, 64'd1024, 1, 0, 1, 1, 0},
    '{ROW_REPORT, 0, 0, 0, 0, 0, 0, 1, 64'd3077, 0, 0, 0, 0, 0},
    '{ROW_REPORT, 0, 0, 0, 0, 0, 0, 0, 64'd9999, 0, 0, 0, 0, 0},
    '{ROW_REPORT, 0, 0, 0, 0, 0, 0, 1, 64'd100, 0, 0, 0, 0, 0},
    '{ROW_REPORT, 0, 0, 1, 0, 0, 0, 1, 64'd5, 1, 1, 0, 0, 0},
    '{ROW_REPORT, 0, 0, 7, 3, 7, 1, 1, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1, 0, 0, 0},
    '{ROW_REPORT, 0, 0, 0, 2, 0, 0, 1, 64'd2048, 1, 1, 0, 0, 0},
    '{ROW_REPORT, 0, 0, 0, 0, 4, 1, 1, 64'd2048, 1, 1, 0, 0, 0},
    '{ROW_REPORT, 0, 0, 0, 1, 0, 1, 1, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0},
    '{ROW_WRITE, CFG_CARDS_PRESENT, 24'd4, 0, 0, 0, 0, 0, 64'd0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, CFG_PERIOD_FRAMES, 24'd0, 0, 0, 0, 0, 0, 64'd0, 0, 0, 0, 0, 0},
    '{ROW_REPORT, 0, 0, 3, 1, 3, 0, 1, 64'd5000, 1, 0, 0, 0, 5000},
    '{ROW_REPORT, 0, 0, 3, 1, 0, 1, 1, 64'h1_0000_0007, 1, 0, 0, 0, 7},
    '{ROW_WRITE, CFG_PERIOD_FRAMES, 24'hFFFFFF, 0, 0, 0, 0, 0, 64'd0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, CFG_PERIOD_COUNT, 24'hFFF800, 0, 0, 0, 0, 0, 64'd0, 0, 0, 0, 0, 0},
    '{ROW_REPORT, 0, 0, 3, 1, 3, 0, 1, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0},
    '{ROW_WRITE, CFG_CARDS_PRESENT, 24'h7, 0, 0, 0, 0, 0, 64'd0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, CFG_PERIOD_COUNT, 24'h7FF, 0, 0, 0, 0, 0, 64'd0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, CFG_PERIOD_FRAMES, 24'd1, 0, 0, 0, 0, 0, 64'd0, 0, 0, 0, 0, 0},
    '{ROW_REPORT, 0, 0, 4, 0, 0, 0, 1, 64'd0, 1, 1, 0, 0, 0},
    '{ROW_REPORT, 0, 0, 2, 0, 2, 0, 1, 64'd1500, 0, 0, 0, 0, 0},
    '{ROW_WRITE, CFG_UNUSED, 24'hFFFFFF, 0, 0, 0, 0, 0, 64'd0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, CFG_CARDS_PRESENT, 24'd0, 0, 0, 0, 0, 0, 64'd0, 0, 0, 0, 0, 0},
    '{ROW_REPORT, 0, 0, 0, 0, 0, 0, 1, 64'd0, 1, 1, 0, 0, 0},
    '{ROW_WRITE, CFG_CARDS_PRESENT, 24'd4, 0, 0, 0, 0, 0, 64'd0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, CFG_PERIOD_COUNT, 24'd3, 0, 0, 0, 0, 0, 64'd0, 0, 0, 0, 0, 0},
    '{ROW_REPORT, 0, 0, 2, 0, 2, 0, 1, 64'd1501, 0, 0, 0, 0, 0},
    '{ROW_REPORT, 0, 0, 2, 0, 2, 0, 1, 64'd1505, 0, 0, 0, 0, 0},
    '{ROW_REPORT, 0, 0, 1, 1, 1, 0, 1, 64'h8000_0000_0000_0000, 0, 0, 0, 0, 0}
  };

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  logic [PF_W-1:0]    period_frames_reg = PF_RESET;
  logic [PC_W-1:0]    period_count_reg  = PC_RESET;
  logic [CARDS_W-1:0] cards_present_reg = CARDS_RESET;
  logic [POS_W-1:0]   boundary_mem [STREAM_TOTAL];
  logic [IDX_W-1:0]   ring_mem     [STREAM_TOTAL];
  logic [FRAG_W-1:0]  fragment_mem [STREAM_TOTAL];

  result_t pending_results [$];
  int      mismatches    = 0;
  int      quiet_cycles  = 0;
  int      send_idle_pct = 6;
  int      recv_idle_pct = 87;

  audio_period_position_tracker_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  function automatic bit stream_valid(report_t r);
    return r.card < cards_present_reg && int'(r.card) < MAX_CARDS &&
           int'(r.pcm) < PCMS_PER_CARD && int'(r.sub) < PLAYBACK_SUBS;
  endfunction

  function automatic logic [SLOT_W-1:0] stream_slot(report_t r);
    return SLOT_W'((int'(r.card) * PCMS_PER_CARD + int'(r.pcm)) * STREAMS_PER_PCM +
                   (r.capture ? PLAYBACK_SUBS : int'(r.sub)));
  endfunction

  function automatic result_t track_report(report_t r);
    result_t           res;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  bnd;
    logic [POS_W-1:0]  frames;
    logic [POS_W-1:0]  steps;
    logic [POS_W-1:0]  ring_len;
    logic [POS_W-1:0]  ring_pos;
    logic [POS_W-1:0]  distance;
    res = '0;
    if (!stream_valid(r)) begin
      res.error = 1'b1;
      return res;
    end
    slot = stream_slot(r);
    if (r.running) begin
      bnd    = boundary_mem[slot];
      frames = POS_W'(period_frames_reg);
      if (frames != 0 && r.pos >= bnd && r.pos - bnd >= frames) begin
        steps    = (r.pos - bnd) / frames;
        ring_len = (period_count_reg > INDEX_LIMIT) ? POS_W'(INDEX_LIMIT)
                                                    : POS_W'(period_count_reg);
        ring_pos = POS_W'(ring_mem[slot]);
        bnd      = bnd + steps * frames;
        res.elapsed = 1'b1;
        if (ring_len == 0) begin
          ring_pos = 0;
        end else begin
          ring_pos = (ring_pos + 1 >= ring_len) ? 0 : ring_pos + 1;
          ring_pos = (ring_pos + (steps - 1) % ring_len) % ring_len;
        end
        ring_mem[slot]     = ring_pos[IDX_W-1:0];
        boundary_mem[slot] = bnd;
      end
      distance           = r.pos - bnd;
      fragment_mem[slot] = distance[FRAG_W-1:0];
    end
    res.index    = ring_mem[slot];
    res.fragment = fragment_mem[slot];
    return res;
  endfunction

  task automatic send_report(input report_t r, input bit typed, input result_t want);
    result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'(r);
    do @(posedge clk); while (!in_tready);
    predicted = track_report(r);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_PERIOD_FRAMES: period_frames_reg = val;
      CFG_PERIOD_COUNT:  period_count_reg  = val[PC_W-1:0];
      CFG_CARDS_PRESENT: cards_present_reg = val[CARDS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic randomize_settings();
    logic [CFG_DATA_W-1:0] val;
    case ($urandom_range(0, 7))
      0:       val = 24'd0;
      1:       val = 24'd1;
      2:       val = 24'hFFFFFF;
      3, 4:    val = CFG_DATA_W'($urandom_range(2, 64));
      default: val = CFG_DATA_W'($urandom_range(65, 20000));
    endcase
    write_reg(CFG_PERIOD_FRAMES, val);
    val = CFG_DATA_W'($urandom);
    case ($urandom_range(0, 7))
      0:       val[PC_W-1:0] = 11'd0;
      1:       val[PC_W-1:0] = 11'd1;
      2:       val[PC_W-1:0] = INDEX_LIMIT;
      3:       val[PC_W-1:0] = 11'h7FF;
      default: val[PC_W-1:0] = PC_W'($urandom_range(2, 16));
    endcase
    write_reg(CFG_PERIOD_COUNT, val);
    val = CFG_DATA_W'($urandom);
    case ($urandom_range(0, 15))
      0:          val[CARDS_W-1:0] = 3'd0;
      1:          val[CARDS_W-1:0] = CARDS_W'($urandom_range(5, 7));
      2, 3, 4, 5: val[CARDS_W-1:0] = CARDS_W'($urandom_range(1, 3));
      default:    val[CARDS_W-1:0] = 3'd4;
    endcase
    write_reg(CFG_CARDS_PRESENT, val);
    if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
  endtask

  // Most reports land a few periods past the stored boundary of a valid
  // stream; the rest are stray addresses, stopped streams and odd positions.
  function automatic report_t make_report();
    report_t          r;
    int               cards;
    logic [POS_W-1:0] bnd;
    logic [POS_W-1:0] span;
    cards = (int'(cards_present_reg) > MAX_CARDS) ? MAX_CARDS : int'(cards_present_reg);
    if ($urandom_range(0, 9) == 0) begin
      r.card    = CARD_W'($urandom);
      r.pcm     = PCM_W'($urandom);
      r.sub     = SUB_W'($urandom);
      r.capture = 1'($urandom);
    end else begin
      r.card    = (cards == 0) ? '0 : CARD_W'($urandom_range(0, cards - 1));
      r.pcm     = PCM_W'($urandom_range(0, PCMS_PER_CARD - 1));
      r.sub     = SUB_W'($urandom_range(0, PLAYBACK_SUBS - 1));
      r.capture = ($urandom_range(0, 3) == 0);
    end
    r.running = ($urandom_range(0, 9) != 0);
    bnd  = stream_valid(r) ? boundary_mem[stream_slot(r)] : '0;
    span = 3 * POS_W'(period_frames_reg) + 2;
    case ($urandom_range(0, 9))
      0:       r.pos = {$urandom, $urandom};
      1:       r.pos = bnd - POS_W'($urandom_range(1, 5000));
      2:       r.pos = 64'hFFFF_FFFF_FFFF_FFFF - POS_W'($urandom_range(0, 3000));
      default: r.pos = bnd + ({$urandom, $urandom} % span);
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(result_t)-1:0];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("index_error", 64'(want.error), 64'(got.error));
        check_field("period_elapsed", 64'(want.elapsed), 64'(got.elapsed));
        check_field("period_index", 64'(want.index), 64'(got.index));
        check_field("period_fragment", 64'(want.fragment), 64'(got.fragment));
      end
    end
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    report_t r;
    result_t want;
    boundary_mem = '{default: '0};
    ring_mem     = '{default: '0};
    fragment_mem = '{default: '0};
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (plan[i].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        r = '{plan[i].pos, plan[i].running, plan[i].capture, plan[i].sub,
              plan[i].pcm, plan[i].card};
        want = '{plan[i].frag, plan[i].idx, plan[i].el, plan[i].err};
        send_report(r, plan[i].typed, want);
      end
    end

    for (int mode = 0; mode < 3; mode++) begin
      wait_idle();
      case (mode)
        0: begin
          send_idle_pct = 6;
          recv_idle_pct = 87;
        end
        1: begin
          send_idle_pct = 87;
          recv_idle_pct = 6;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        wait_idle();
        randomize_settings();
        repeat (SEG_ITEMS) begin
          r = make_report();
          send_report(r, 1'b0, '0);
        end
      end
    end

    wait_idle();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
